// ----- src/sigmoid_neuron_trainer_unit_macros.svh -----
// Assertion macros used by the checker file.
`ifndef SIGMOID_NEURON_TRAINER_UNIT_MACROS_SVH
`define SIGMOID_NEURON_TRAINER_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define SNT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define SNT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/snt_pkg.sv -----
package snt_pkg;

    localparam int MAX_INPUTS = 256;
    localparam int ADDR_W     = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;
    localparam int MUL_W      = 24;
    localparam int PROD_W     = 2 * MUL_W;
    localparam int ACC_W      = 48;
    localparam int Q_FRAC     = 12;
    localparam logic signed [15:0] ONE_Q = 16'sd4096;

    localparam logic [2:0] REQ_LOAD    = 3'd0;
    localparam logic [2:0] REQ_FORWARD = 3'd1;
    localparam logic [2:0] REQ_OUT_DLT = 3'd2;
    localparam logic [2:0] REQ_HID_DLT = 3'd3;
    localparam logic [2:0] REQ_UPDATE  = 3'd4;
    localparam logic [2:0] REQ_READ    = 3'd5;

    localparam logic [1:0] KIND_ACT    = 2'd0;
    localparam logic [1:0] KIND_DELTA  = 2'd1;
    localparam logic [1:0] KIND_WEIGHT = 2'd2;

    localparam logic REG_LEARNING_RATE = 1'b0;
    localparam logic REG_IS_BIAS       = 1'b1;

    typedef logic [15:0] sig_tab_t [256];

    // Restoring long division, used only while building the table.
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [64:0] rem;
        logic [63:0] quo;
        rem = '0;
        quo = '0;
        for (int i = 63; i >= 0; i--) begin
            rem = {rem[63:0], num[i]};
            if (rem >= {1'b0, den}) begin
                rem    = rem - {1'b0, den};
                quo[i] = 1'b1;
            end
        end
        return quo;
    endfunction

    // Logistic table at the midpoints of each top-byte interval.
    function automatic sig_tab_t sig_build();
        sig_tab_t   t;
        logic [63:0] term;
        logic [63:0] pos;
        logic [63:0] neg;
        logic [63:0] a;
        logic [63:0] q;
        logic [63:0] e;
        logic [63:0] den;
        logic [63:0] v;
        term = 64'd1 << 60;
        pos  = term;
        neg  = '0;
        for (int n = 1; n <= 10; n++) begin
            term = udiv64(term, 64'(32 * n));
            if ((n % 2) == 1) neg = neg + term;
            else              pos = pos + term;
        end
        a = ((pos - neg) + (64'd1 << 29)) >> 30;
        q = (a * a + (64'd1 << 29)) >> 30;
        e = a;
        for (int k = 0; k < 128; k++) begin
            den        = (64'd1 << 30) + e;
            v          = udiv64((64'd1 << 42) + (den >> 1), den);
            t[k]       = v[15:0];
            t[255 - k] = 16'd4096 - v[15:0];
            e          = (e * q + (64'd1 << 29)) >> 30;
        end
        return t;
    endfunction

    localparam sig_tab_t SIG_TAB = sig_build();

    function automatic logic signed [15:0] sat16(input logic signed [63:0] x);
        if (x > 64'sd32767)       return 16'sh7fff;
        else if (x < -64'sd32768) return 16'sh8000;
        else                      return x[15:0];
    endfunction

endpackage

// ----- src/sigmoid_neuron_trainer_unit.sv -----
// Channel    | Handshake           | Payload
// -----------+---------------------+-------------------------------------------
// input      | in_valid / in_ready | req_type, index, value, second_value, last
// result     | out_valid/out_ready | result_kind, result_value
// config     | cfg_wen             | cfg_index, cfg_data
//
// One transaction is worked at a time; in_ready is high only while the sequencer is idle.
// Transaction timing is set by the single shared 24x24 multiplier and the registered
// weight memory read.
// Reset (rst_n low, asynchronous) clears control, accumulator, activation and delta;
// the weight memory is not cleared and needs no clearing pass.
// A result that finds the output register still held waits in its final state with
// in_ready low until out_ready frees the register, so a stalled receiver also stalls input.
module sigmoid_neuron_trainer_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [2:0]         req_type,
    input  logic [7:0]         index,
    input  logic signed [15:0] value,
    input  logic signed [15:0] second_value,
    input  logic               last,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         result_kind,
    output logic signed [15:0] result_value,
    input  logic               cfg_wen,
    input  logic               cfg_index,
    input  logic [14:0]        cfg_data
);
    import snt_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE, ST_MUL, ST_ACC, ST_SIG, ST_PRIME, ST_PRIMEW, ST_D2, ST_DSAT,
        ST_DLO, ST_DHI, ST_DCOMB, ST_UPD_P, ST_UPD_Q, ST_UPD_W, ST_RDW, ST_OUT
    } state_t;

    state_t state_reg;

    // Configuration registers.
    logic [14:0] lr_reg;
    logic        bias_reg;

    // Latched transaction.
    logic [2:0]         req_reg;
    logic [ADDR_W-1:0]  addr_reg;
    logic               ok_reg;
    logic signed [15:0] val_reg;
    logic signed [15:0] val2_reg;
    logic               last_reg;

    // Neuron state.
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [15:0]       wsum_reg;
    logic signed [15:0]       act_reg;
    logic signed [15:0]       delta_reg;
    logic signed [21:0]       prime_reg;
    logic signed [PROD_W-1:0] part_reg;

    // Pending result and output register.
    logic [1:0]         pend_kind_reg;
    logic signed [15:0] pend_val_reg;
    logic               out_valid_reg;
    logic [1:0]         out_kind_reg;
    logic signed [15:0] out_val_reg;

    logic               accept;
    logic               in_ok;
    logic [ADDR_W-1:0]  in_addr;
    logic [15:0]        ram_q;
    logic signed [15:0] w_cur;
    logic               ram_we;
    logic [ADDR_W-1:0]  ram_waddr;
    logic [15:0]        ram_wdata;
    logic signed [MUL_W-1:0]  mul_a;
    logic signed [MUL_W-1:0]  mul_b;
    logic signed [PROD_W-1:0] prod;
    logic signed [15:0]       act_eff;
    logic signed [17:0]       one_minus;
    logic signed [17:0]       diff;
    logic signed [35:0]       acc_sh;
    logic signed [15:0]       sum_sat;
    logic signed [15:0]       prod_sat;
    logic signed [63:0]       full;
    logic signed [15:0]       w_new;

    assign accept    = in_valid && in_ready;
    assign in_ready  = (state_reg == ST_IDLE);
    assign in_ok     = (32'(index) < MAX_INPUTS);
    assign in_addr   = ADDR_W'(index);
    assign out_valid    = out_valid_reg;
    assign result_kind  = out_kind_reg;
    assign result_value = out_val_reg;

    // A bias node reads as exactly one, which makes its derivative zero.
    assign act_eff   = bias_reg ? ONE_Q : act_reg;
    assign one_minus = 18'(ONE_Q) - 18'(act_eff);
    assign diff      = 18'(act_eff) - 18'(val_reg);
    assign acc_sh    = 36'(acc_reg >>> Q_FRAC);
    assign sum_sat   = sat16(64'(acc_sh));
    assign prod_sat  = sat16(64'(prod >>> Q_FRAC));
    assign w_cur     = ok_reg ? signed'(ram_q) : 16'sd0;
    assign full      = (64'(prod) <<< 18) + 64'(part_reg);
    assign w_new     = sat16(64'(signed'(ram_q)) - 64'(prod_sat));

    // Weight memory write: loads at acceptance, updates at the end of an update.
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = in_addr;
        ram_wdata = value;
        if (accept && req_type == REQ_LOAD && in_ok)
        begin
            ram_we = 1'b1;
        end
        else if (state_reg == ST_UPD_W)
        begin
            ram_we    = 1'b1;
            ram_waddr = addr_reg;
            ram_wdata = w_new;
        end
    end

    // Operand selection for the shared multiplier.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_MUL:
            begin
                if (req_reg == REQ_FORWARD)
                begin
                    mul_a = MUL_W'(w_cur);
                    mul_b = MUL_W'(val_reg);
                end
                else
                begin
                    mul_a = MUL_W'(val_reg);
                    mul_b = MUL_W'(val2_reg);
                end
            end
            ST_PRIME:
            begin
                mul_a = MUL_W'(act_eff);
                mul_b = MUL_W'(one_minus);
            end
            ST_D2:
            begin
                mul_a = MUL_W'(diff);
                mul_b = MUL_W'(prime_reg);
            end
            ST_DLO:
            begin
                mul_a = MUL_W'(signed'({1'b0, acc_sh[17:0]}));
                mul_b = MUL_W'(prime_reg);
            end
            ST_DHI:
            begin
                mul_a = MUL_W'(signed'(acc_sh[35:18]));
                mul_b = MUL_W'(prime_reg);
            end
            ST_UPD_P:
            begin
                mul_a = MUL_W'(signed'({1'b0, lr_reg}));
                mul_b = MUL_W'(delta_reg);
            end
            ST_UPD_Q:
            begin
                mul_a = MUL_W'(prod_sat);
                mul_b = MUL_W'(val_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    snt_ram #(
        .DEPTH (MAX_INPUTS),
        .WIDTH (16),
        .AW    (ADDR_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (accept),
        .raddr (in_addr),
        .rdata (ram_q)
    );

    snt_mul u_mul (
        .clk      (clk),
        .a        (mul_a),
        .b        (mul_b),
        .prod_reg (prod)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lr_reg   <= 15'd2048;
            bias_reg <= 1'b0;
        end
        else if (cfg_wen)
        begin
            case (cfg_index)
                REG_LEARNING_RATE: lr_reg   <= cfg_data;
                REG_IS_BIAS:       bias_reg <= cfg_data[0];
                default:           lr_reg   <= lr_reg;
            endcase
        end
    end

    // Payload capture needs no reset.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg  <= req_type;
            addr_reg <= in_addr;
            ok_reg   <= in_ok;
            val_reg  <= value;
            val2_reg <= second_value;
            last_reg <= last;
        end
        if (state_reg == ST_PRIMEW)
        begin
            prime_reg <= 22'(prod >>> Q_FRAC);
        end
        if (state_reg == ST_DHI)
        begin
            part_reg <= prod;
        end
    end

    // Sequencer, neuron state and output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            acc_reg       <= '0;
            wsum_reg      <= '0;
            act_reg       <= '0;
            delta_reg     <= '0;
            pend_kind_reg <= KIND_ACT;
            pend_val_reg  <= '0;
            out_valid_reg <= 1'b0;
            out_kind_reg  <= KIND_ACT;
            out_val_reg   <= '0;
        end
        else
        begin
            // In ST_OUT the output register is reloaded below instead.
            if (out_valid_reg && out_ready && state_reg != ST_OUT)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        case (req_type)
                            REQ_FORWARD:
                            begin
                                if (!bias_reg)
                                begin
                                    state_reg <= ST_MUL;
                                end
                                else if (last)
                                begin
                                    acc_reg       <= '0;
                                    pend_kind_reg <= KIND_ACT;
                                    pend_val_reg  <= ONE_Q;
                                    state_reg     <= ST_OUT;
                                end
                            end
                            REQ_OUT_DLT: state_reg <= ST_PRIME;
                            REQ_HID_DLT: state_reg <= ST_MUL;
                            REQ_UPDATE:
                            begin
                                if (!bias_reg && in_ok)
                                begin
                                    state_reg <= ST_UPD_P;
                                end
                            end
                            REQ_READ:    state_reg <= ST_RDW;
                            default:     state_reg <= ST_IDLE;
                        endcase
                    end
                end
                ST_MUL: state_reg <= ST_ACC;
                ST_ACC:
                begin
                    acc_reg <= acc_reg + prod;
                    if (!last_reg)
                    begin
                        state_reg <= ST_IDLE;
                    end
                    else if (req_reg == REQ_FORWARD)
                    begin
                        state_reg <= ST_SIG;
                    end
                    else
                    begin
                        state_reg <= ST_PRIME;
                    end
                end
                ST_SIG:
                begin
                    wsum_reg      <= sum_sat;
                    act_reg       <= signed'(SIG_TAB[sum_sat[15:8]]);
                    acc_reg       <= '0;
                    pend_kind_reg <= KIND_ACT;
                    pend_val_reg  <= signed'(SIG_TAB[sum_sat[15:8]]);
                    state_reg     <= ST_OUT;
                end
                ST_PRIME:  state_reg <= ST_PRIMEW;
                ST_PRIMEW: state_reg <= (req_reg == REQ_OUT_DLT) ? ST_D2 : ST_DLO;
                ST_D2:     state_reg <= ST_DSAT;
                ST_DSAT:
                begin
                    delta_reg     <= prod_sat;
                    pend_kind_reg <= KIND_DELTA;
                    pend_val_reg  <= prod_sat;
                    state_reg     <= ST_OUT;
                end
                ST_DLO: state_reg <= ST_DHI;
                ST_DHI: state_reg <= ST_DCOMB;
                ST_DCOMB:
                begin
                    // The two partial products rebuild the full hidden-delta product.
                    delta_reg     <= sat16(full >>> Q_FRAC);
                    pend_kind_reg <= KIND_DELTA;
                    pend_val_reg  <= sat16(full >>> Q_FRAC);
                    acc_reg       <= '0;
                    state_reg     <= ST_OUT;
                end
                ST_UPD_P: state_reg <= ST_UPD_Q;
                ST_UPD_Q: state_reg <= ST_UPD_W;
                ST_UPD_W: state_reg <= ST_IDLE;
                ST_RDW:
                begin
                    pend_kind_reg <= KIND_WEIGHT;
                    pend_val_reg  <= w_cur;
                    state_reg     <= ST_OUT;
                end
                ST_OUT:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg <= 1'b1;
                        out_kind_reg  <= pend_kind_reg;
                        out_val_reg   <= pend_val_reg;
                        state_reg     <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

// ----- src/snt_ram.sv -----
module snt_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- src/snt_mul.sv -----
module snt_mul (
    input  logic                             clk,
    input  logic signed [snt_pkg::MUL_W-1:0]  a,
    input  logic signed [snt_pkg::MUL_W-1:0]  b,
    output logic signed [snt_pkg::PROD_W-1:0] prod_reg
);
    import snt_pkg::*;

    logic signed [PROD_W-1:0] prod_next;

    assign prod_next = PROD_W'(a) * PROD_W'(b);

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

endmodule

// ----- src/snt_checker.sv -----
`include "sigmoid_neuron_trainer_unit_macros.svh"

module snt_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic [2:0]         req_type,
    input logic               out_valid,
    input logic               out_ready,
    input logic signed [15:0] result_value
);
    import snt_pkg::*;

    `SNT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(result_value), "result dropped or changed while stalled")
    `SNT_ASSERT_NEXT(a_load_quiet, in_valid && in_ready && req_type == REQ_LOAD, !$rose(out_valid), "weight load produced a result")
    `SNT_ASSERT_NEXT(a_read_busy, in_valid && in_ready && req_type == REQ_READ, !in_ready, "input taken while a weight read is in flight")
    `SNT_ASSERT_NEXT(a_load_ready, in_valid && in_ready && req_type == REQ_LOAD, in_ready, "weight load did not finish in one cycle")

endmodule

bind sigmoid_neuron_trainer_unit snt_checker u_snt_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .req_type     (req_type),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .result_value (result_value)
);

// ----- tb/tb_top.sv -----
// Scoreboard and bit-accurate predictor of the neuron. Every accepted request
// goes through note_request, which updates the private copy of the state and
// queues the result the request should produce. check_result pops the oldest
// expected result and compares it with what the block delivered.
class neuron_scoreboard;
    logic signed [15:0] wt [256];
    logic [47:0]        acc;
    logic signed [15:0] wsum;
    logic signed [15:0] act;
    logic signed [15:0] dlt;
    logic [14:0]        rate;
    bit                 bias;
    logic [15:0]        sig_rom [256];
    logic [1:0]         pending_kind [$];
    logic signed [15:0] pending_value [$];
    int                 errors;

    function new();
        longint unsigned term, pos, neg, a, q, e, den, v;
        term = 64'd1 << 60;
        pos  = term;
        neg  = 0;
        // e^(-1/32) from its series, then its odd powers by repeated multiplication with its square.
        for (int n = 1; n <= 10; n++)
        begin
            term = term / longint'(32 * n);
            if (n % 2 == 1) neg += term;
            else pos += term;
        end
        a = ((pos - neg) + (64'd1 << 29)) >> 30;
        q = (a * a + (64'd1 << 29)) >> 30;
        e = a;
        for (int k = 0; k < 128; k++)
        begin
            den = (64'd1 << 30) + e;
            v   = ((64'd1 << 42) + den / 2) / den;
            sig_rom[k]       = v[15:0];
            sig_rom[255 - k] = 16'd4096 - v[15:0];
            e = (e * q + (64'd1 << 29)) >> 30;
        end
        foreach (wt[i]) wt[i] = '0;
        acc    = '0;
        wsum   = '0;
        act    = '0;
        dlt    = '0;
        rate   = 15'd2048;
        bias   = 1'b0;
        errors = 0;
    endfunction

    function logic signed [15:0] clip16(longint x);
        if (x > 32767) return 16'sh7fff;
        if (x < -32768) return 16'sh8000;
        return x[15:0];
    endfunction

    function longint slope();
        longint av;
        av = bias ? 4096 : longint'(act);
        return (av * (4096 - av)) >>> 12;
    endfunction

    function void push_result(logic [1:0] kind, logic signed [15:0] val);
        pending_kind.push_back(kind);
        pending_value.push_back(val);
    endfunction

    function void note_request(logic [2:0] req, logic [7:0] idx, logic signed [15:0] val,
                               logic signed [15:0] val2, logic lst);
        longint w, v, v2, sum, p, qq, av;
        logic signed [15:0] s;
        w  = longint'(wt[idx]);
        v  = longint'(val);
        v2 = longint'(val2);
        case (req)
            snt_pkg::REQ_LOAD:
                wt[idx] = val;
            snt_pkg::REQ_FORWARD:
            begin
                if (bias)
                begin
                    if (lst)
                    begin
                        acc = '0;
                        push_result(snt_pkg::KIND_ACT, 16'sd4096);
                    end
                end
                else
                begin
                    p   = w * v;
                    acc = acc + p[47:0];
                    if (lst)
                    begin
                        sum  = longint'($signed(acc));
                        s    = clip16(sum >>> 12);
                        wsum = s;
                        act  = sig_rom[s[15:8]];
                        acc  = '0;
                        push_result(snt_pkg::KIND_ACT, act);
                    end
                end
            end
            snt_pkg::REQ_OUT_DLT:
            begin
                av  = bias ? 4096 : longint'(act);
                dlt = clip16(((av - v) * slope()) >>> 12);
                push_result(snt_pkg::KIND_DELTA, dlt);
            end
            snt_pkg::REQ_HID_DLT:
            begin
                p   = v * v2;
                acc = acc + p[47:0];
                if (lst)
                begin
                    sum = longint'($signed(acc));
                    dlt = clip16(((sum >>> 12) * slope()) >>> 12);
                    acc = '0;
                    push_result(snt_pkg::KIND_DELTA, dlt);
                end
            end
            snt_pkg::REQ_UPDATE:
            begin
                if (!bias)
                begin
                    p  = longint'(clip16((longint'(rate) * longint'(dlt)) >>> 12));
                    qq = longint'(clip16((p * v) >>> 12));
                    wt[idx] = clip16(w - qq);
                end
            end
            snt_pkg::REQ_READ:
                push_result(snt_pkg::KIND_WEIGHT, wt[idx]);
            default:
                ;
        endcase
    endfunction

    function void check_result(logic [1:0] kind, logic signed [15:0] val);
        logic [1:0]         ek;
        logic signed [15:0] ev;
        if (pending_kind.size() == 0)
        begin
            $display("%0t: unexpected result kind=%0d value=%0d", $time, kind, val);
            errors++;
            return;
        end
        ek = pending_kind.pop_front();
        ev = pending_value.pop_front();
        if (kind !== ek)
        begin
            $display("%0t: result_kind expected %0d actual %0d", $time, ek, kind);
            errors++;
        end
        if (val !== ev)
        begin
            $display("%0t: result_value expected %0d actual %0d", $time, ev, val);
            errors++;
        end
    endfunction
endclass

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import snt_pkg::*;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [2:0]         req_type;
    logic [7:0]         index;
    logic signed [15:0] value;
    logic signed [15:0] second_value;
    logic               last;
    logic               out_valid;
    logic               out_ready;
    logic [1:0]         result_kind;
    logic signed [15:0] result_value;
    logic               cfg_wen;
    logic               cfg_index;
    logic [14:0]        cfg_data;

    neuron_scoreboard sb;

    // Weight entries that hold a defined value; only these are ever used or read.
    bit       loaded [256];
    int       loaded_list [$];
    int       sent_count;
    int       burst_left;

    sigmoid_neuron_trainer_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .req_type     (req_type),
        .index        (index),
        .value        (value),
        .second_value (second_value),
        .last         (last),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .result_kind  (result_kind),
        .result_value (result_value),
        .cfg_wen      (cfg_wen),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog: far beyond the slowest legal run of all phases.
    initial
    begin
        #5ms;
        $display("TEST FAILED");
        $finish;
    end

    // Monitor both channels on the same edge the block samples them. The
    // stimulus only changes through nonblocking assignments, so the values
    // seen here are the ones the block acted on.
    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
            sb.note_request(req_type, index, value, second_value, last);
        if (rst_n && out_valid && out_ready)
            sb.check_result(result_kind, result_value);
    end

    // The receiver alternates between windows of full throughput and windows
    // where it stalls at random, with occasional long stalls.
    int rx_cycle;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_cycle  <= 0;
            out_ready <= 1'b0;
        end
        else
        begin
            rx_cycle <= rx_cycle + 1;
            if (rx_cycle[8:7] == 2'd0)
                out_ready <= 1'b1;
            else if (rx_cycle[8:7] == 2'd3)
                out_ready <= ($urandom_range(0, 15) == 0);
            else
                out_ready <= ($urandom_range(0, 2) != 0);
        end
    end

    // Drives one transaction and holds it until the block accepts it. The
    // sender works in bursts; between bursts valid drops for a random gap.
    task automatic send(input logic [2:0] req, input int idx, input logic signed [15:0] val,
                        input logic signed [15:0] val2, input logic lst);
        in_valid     <= 1'b1;
        req_type     <= req;
        index        <= idx[7:0];
        value        <= val;
        second_value <= val2;
        last         <= lst;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if (req <= REQ_READ)
            sent_count++;
        if (req == REQ_LOAD && !loaded[idx])
        begin
            loaded[idx] = 1'b1;
            loaded_list.push_back(idx);
        end
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = $urandom_range(0, 12);
            if ($urandom_range(0, 2) != 0)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
        end
    endtask

    // A Q4.12 value: sometimes the full 16-bit range, otherwise within +-4.0, +-1.0 or +-0.125.
    function automatic logic signed [15:0] rand_q();
        logic [15:0] r;
        r = 16'($urandom());
        case ($urandom_range(0, 3))
            0: return r;
            1: return $signed(16'($urandom_range(0, 8192))) - 16'sd4096;
            2: return $signed(16'($urandom_range(0, 1024))) - 16'sd512;
            default: return $signed(16'($urandom_range(0, 32768))) - 16'sd16384;
        endcase
    endfunction

    function automatic int pick_loaded();
        return loaded_list[$urandom_range(0, loaded_list.size() - 1)];
    endfunction

    // Waits until no result is outstanding, then lets the pipeline settle so
    // that a trailing request without a result has also finished.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending_kind.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_cfg(input logic reg_sel, input logic [14:0] data);
        cfg_wen   <= 1'b1;
        cfg_index <= reg_sel;
        cfg_data  <= data;
        @(posedge clk);
        cfg_wen   <= 1'b0;
        if (reg_sel == REG_LEARNING_RATE)
            sb.rate = data;
        else
            sb.bias = data[0];
        @(posedge clk);
    endtask

    task automatic random_traffic(input int quota);
        int stop_at;
        int n;
        int r;
        stop_at = sent_count + quota;
        while (sent_count < stop_at)
        begin
            r = $urandom_range(0, 99);
            if (r < 10)
                send(REQ_LOAD, $urandom_range(0, 255), rand_q(), 16'($urandom()),
                     1'($urandom()));
            else if (r < 45)
            begin
                // Training pass: forward stream, then an optional output delta and up to three updates.
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
                for (int i = 0; i < n; i++)
                    send(REQ_FORWARD, pick_loaded(), rand_q(), 16'($urandom()), i == n - 1);
                if ($urandom_range(0, 1))
                    send(REQ_OUT_DLT, $urandom(), rand_q(), 16'($urandom()), 1'($urandom()));
                repeat ($urandom_range(0, 3))
                    send(REQ_UPDATE, pick_loaded(), rand_q(), 16'($urandom()),
                         1'($urandom()));
            end
            else if (r < 60)
            begin
                n = $urandom_range(1, 6);
                for (int i = 0; i < n; i++)
                    send(REQ_HID_DLT, $urandom(), rand_q(), rand_q(), i == n - 1);
            end
            else if (r < 70)
                send(REQ_OUT_DLT, $urandom(), rand_q(), 16'($urandom()), 1'($urandom()));
            else if (r < 80)
                send(REQ_UPDATE, pick_loaded(), rand_q(), 16'($urandom()), 1'($urandom()));
            else if (r < 90)
                send(REQ_READ, pick_loaded(), 16'($urandom()), 16'($urandom()),
                     1'($urandom()));
            else if (r < 95)
                send(3'($urandom_range(6, 7)), $urandom(), 16'($urandom()), 16'($urandom()),
                     1'($urandom()));
            else
            begin
                // Broken stream: forward and hidden elements mixed in one sum.
                repeat ($urandom_range(1, 4))
                begin
                    if ($urandom_range(0, 1))
                        send(REQ_FORWARD, pick_loaded(), rand_q(), 16'($urandom()), 1'b0);
                    else
                        send(REQ_HID_DLT, $urandom(), rand_q(), rand_q(), 1'b0);
                end
                if ($urandom_range(0, 1))
                    send(REQ_HID_DLT, $urandom(), rand_q(), rand_q(), 1'b1);
                else
                    send(REQ_FORWARD, pick_loaded(), rand_q(), 16'($urandom()), 1'b1);
            end
        end
        drain();
    endtask

    initial
    begin
        sb           = new();
        sent_count   = 0;
        burst_left   = 0;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        req_type     = REQ_LOAD;
        index        = '0;
        value        = '0;
        second_value = '0;
        last         = 1'b0;
        cfg_wen      = 1'b0;
        cfg_index    = REG_LEARNING_RATE;
        cfg_data     = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part at reset settings: field extremes and every request.
        send(REQ_LOAD, 0, 16'sh7fff, 16'sh7fff, 1'b1);
        send(REQ_LOAD, 255, 16'sh8000, 16'sh8000, 1'b0);
        send(REQ_LOAD, 1, 16'sd4096, 16'sd0, 1'b0);
        send(REQ_LOAD, 128, 16'sd0, 16'sd0, 1'b0);
        send(REQ_READ, 0, 16'sd0, 16'sd0, 1'b0);
        send(REQ_READ, 255, 16'sd0, 16'sd0, 1'b0);
        // Saturating forward sum: largest positive products accumulated.
        send(REQ_FORWARD, 0, 16'sh7fff, 16'sd0, 1'b0);
        send(REQ_FORWARD, 255, 16'sh8000, 16'sd0, 1'b1);
        send(REQ_FORWARD, 1, 16'sd4096, 16'sd0, 1'b1);
        send(REQ_OUT_DLT, 0, 16'sh8000, 16'sd0, 1'b0);
        send(REQ_OUT_DLT, 0, 16'sh7fff, 16'sd0, 1'b0);
        send(REQ_HID_DLT, 0, 16'sh7fff, 16'sh7fff, 1'b0);
        send(REQ_HID_DLT, 0, 16'sh8000, 16'sh8000, 1'b1);
        send(REQ_UPDATE, 1, 16'sh7fff, 16'sd0, 1'b0);
        send(REQ_UPDATE, 255, 16'sh8000, 16'sd0, 1'b0);
        send(REQ_READ, 1, 16'sd0, 16'sd0, 1'b0);
        send(REQ_READ, 255, 16'sd0, 16'sd0, 1'b0);
        // Unknown request codes do nothing.
        send(3'd6, 0, 16'sh7fff, 16'sh7fff, 1'b1);
        send(3'd7, 255, 16'sh8000, 16'sh8000, 1'b0);
        send(REQ_READ, 0, 16'sd0, 16'sd0, 1'b0);
        drain();

        // Bias node with a zero learning rate.
        write_cfg(REG_LEARNING_RATE, 15'd0);
        write_cfg(REG_IS_BIAS, 15'd1);
        send(REQ_FORWARD, 0, 16'sh7fff, 16'sd0, 1'b1);
        send(REQ_UPDATE, 0, 16'sh7fff, 16'sd0, 1'b0);
        send(REQ_READ, 0, 16'sd0, 16'sd0, 1'b0);
        random_traffic(200);

        write_cfg(REG_IS_BIAS, 15'd0);
        random_traffic(250);

        write_cfg(REG_LEARNING_RATE, 15'h7fff);
        random_traffic(250);

        write_cfg(REG_LEARNING_RATE, 15'($urandom_range(0, 32767)));
        write_cfg(REG_IS_BIAS, 15'd1);
        random_traffic(150);

        write_cfg(REG_LEARNING_RATE, 15'($urandom_range(0, 32767)));
        write_cfg(REG_IS_BIAS, 15'd0);
        random_traffic(300);

        if (sb.errors == 0 && sb.pending_kind.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule

// ----- filelist.f -----
+incdir+src
src/snt_pkg.sv
src/snt_ram.sv
src/snt_mul.sv
src/sigmoid_neuron_trainer_unit.sv
src/snt_checker.sv
tb/tb_top.sv
